// ===== rtl/skt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types, tables and helpers for the seed-to-key transform.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned N_BYTES  = 4;
  localparam int unsigned ODD_W    = 3;
  localparam int unsigned ROT_LEFT = 3;

  typedef logic [N_BYTES-1:0][BYTE_W-1:0] skt_bytes_t;

  typedef struct packed {
    skt_bytes_t             mixed;
    logic [ODD_W-1:0]       odd_count;
  } skt_mixed_t;

  // additive constant chosen by the low two bits of a byte
  function automatic logic [BYTE_W-1:0] add_const(input logic [1:0] sel);
    logic [BYTE_W-1:0] c;
    unique case (sel)
      2'd0: c = 8'd145;
      2'd1: c = 8'd24;
      2'd2: c = 8'd211;
      2'd3: c = 8'd2;
    endcase
    return c;
  endfunction

  // source byte index for permuted byte j, under the odd-byte count
  function automatic logic [1:0] perm_index(input logic [ODD_W-1:0] odd_count,
                                            input logic [1:0] j);
    logic [7:0] row;
    unique case (odd_count)
      3'd0:    row = {2'd0, 2'd2, 2'd3, 2'd1};
      3'd1:    row = {2'd1, 2'd0, 2'd2, 2'd3};
      3'd2:    row = {2'd0, 2'd3, 2'd2, 2'd1};
      3'd3:    row = {2'd3, 2'd2, 2'd0, 2'd1};
      3'd4:    row = {2'd3, 2'd1, 2'd0, 2'd2};
      default: row = {2'd0, 2'd2, 2'd3, 2'd1};
    endcase
    return row[j*2 +: 2];
  endfunction

endpackage

// ===== rtl/skt_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_mix
// Per-byte add and rotate of the seed, plus the odd-byte count.
// ----------------------------------------------------------------------------
module skt_mix (
  input  logic [skt_pkg::KEY_W-1:0] seed,
  output skt_pkg::skt_mixed_t       mix
);

  skt_pkg::skt_bytes_t             bytes_mixed;
  logic [skt_pkg::ODD_W-1:0]       odd_sum;

  always_comb begin
    logic [skt_pkg::BYTE_W-1:0] b;
    logic [skt_pkg::BYTE_W-1:0] x;
    odd_sum = '0;
    for (int i = 0; i < skt_pkg::N_BYTES; i++) begin
      // byte 0 is the most significant seed byte
      b = seed[(skt_pkg::N_BYTES-1-i)*skt_pkg::BYTE_W +: skt_pkg::BYTE_W];
      x = b + skt_pkg::add_const(b[1:0]);
      bytes_mixed[i] = {x[skt_pkg::BYTE_W-1-skt_pkg::ROT_LEFT:0],
                        x[skt_pkg::BYTE_W-1 -: skt_pkg::ROT_LEFT]};
      odd_sum = odd_sum + skt_pkg::ODD_W'(bytes_mixed[i][0]);
    end
  end

  assign mix.mixed     = bytes_mixed;
  assign mix.odd_count = odd_sum;

endmodule

// ===== rtl/skt_combine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_combine
// Byte permutation and the two weighted 16-bit words of the key.
// ----------------------------------------------------------------------------
module skt_combine (
  input  skt_pkg::skt_mixed_t       mix,
  output logic [skt_pkg::KEY_W-1:0] key
);

  skt_pkg::skt_bytes_t         n;
  logic [skt_pkg::WORD_W-1:0]  pair0;
  logic [skt_pkg::WORD_W-1:0]  pair1;
  logic [skt_pkg::WORD_W-1:0]  word0;
  logic [skt_pkg::WORD_W-1:0]  word1;

  always_comb begin
    for (int j = 0; j < skt_pkg::N_BYTES; j++) begin
      n[j] = mix.mixed[skt_pkg::perm_index(mix.odd_count, 2'(j))];
    end
  end

  assign pair0 = {n[0], n[1]};
  assign pair1 = {n[2], n[3]};

  // times 3 and times 5 as shift-and-add, wrapping at 16 bits
  assign word0 = pair0 + (pair0 << 1) + (skt_pkg::WORD_W'(n[3]) << 3);
  assign word1 = pair1 + (pair1 << 2) + (skt_pkg::WORD_W'(n[1]) << 3);

  assign key = {word0, word1};

endmodule

// ===== rtl/seed_to_key_transform.sv =====
`timescale 1ns / 1ps
// path: from seed transaction through the input register, then the result register, to the key transaction
// throughput: one seed per cycle, limited only by the key_ready backpressure
// the input register feeds the mix and combine logic straight into the result register
// reset: synchronous active-high rst empties both registers; no other state
// ----------------------------------------------------------------------------
// seed_to_key_transform
// Two-register pipeline mapping a 32-bit seed to a 32-bit response key.
// ----------------------------------------------------------------------------
module seed_to_key_transform (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      seed_valid,
  output logic                      seed_ready,
  input  logic [skt_pkg::KEY_W-1:0] seed_value,
  output logic                      key_valid,
  input  logic                      key_ready,
  output logic [skt_pkg::KEY_W-1:0] key_value
);

  logic                      s1_valid;
  logic [skt_pkg::KEY_W-1:0] s1_seed;
  logic [skt_pkg::KEY_W-1:0] key_next;
  logic                      out_advance;
  skt_pkg::skt_mixed_t       mix;

  assign out_advance = !key_valid || key_ready;
  assign seed_ready  = !s1_valid || out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (seed_ready) begin
      s1_valid <= seed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seed_valid && seed_ready) begin
      s1_seed <= seed_value;
    end
  end

  skt_mix u_mix (
    .seed (s1_seed),
    .mix  (mix)
  );

  skt_combine u_combine (
    .mix (mix),
    .key (key_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (out_advance) begin
      key_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      key_value <= key_next;
    end
  end

  a_accept_loads : assert property (@(posedge clk) disable iff (rst)
    (seed_valid && seed_ready) |=> s1_valid)
    else $error("accepted seed not held in input register");

  a_key_from_seed : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_advance) |=> (key_valid && key_value == $past(key_next)))
    else $error("result register does not hold the transformed seed");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_advance) |=> (s1_valid && $stable(s1_seed)))
    else $error("input register lost a transaction during a stall");

  a_drain : assert property (@(posedge clk) disable iff (rst)
    (!s1_valid && key_valid && key_ready) |=> !key_valid)
    else $error("key repeated after its transaction");

endmodule

// ===== dv/seed_to_key_transform_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seed_to_key_transform_test
// Self-checking bench for the seed-to-key transform. A queue-fed driver offers
// directed corner seeds (byte offset selects, byte wrap, every odd-byte count)
// followed by random seeds. A monitor compares each key against an in-bench
// model. Both sides idle at random, and one long key stall backs up the pipeline.
// ----------------------------------------------------------------------------
module seed_to_key_transform_test;

  localparam int unsigned KEY_W        = skt_pkg::KEY_W;
  localparam int unsigned RANDOM_SEEDS = 1200;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned LONG_HOLD    = 250;
  localparam int unsigned HOLD_AT_KEY  = 300;

  typedef struct {
    logic [KEY_W-1:0] seed;
    logic [KEY_W-1:0] key;
  } key_check_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             seed_valid = 1'b0;
  logic             seed_ready;
  logic [KEY_W-1:0] seed_value = '0;
  logic             key_valid;
  logic             key_ready = 1'b0;
  logic [KEY_W-1:0] key_value;

  logic [KEY_W-1:0] seed_pending [$];
  key_check_t       key_expected [$];

  int unsigned seeds_total   = 0;
  int unsigned seeds_taken   = 0;
  int unsigned keys_seen     = 0;
  int unsigned error_count   = 0;
  int unsigned idle_cycles   = 0;
  int unsigned send_gap      = 0;
  int unsigned send_calm     = 0;
  int unsigned recv_hold     = 0;
  int unsigned recv_calm     = 0;
  bit          long_hold_done = 1'b0;

  seed_to_key_transform dut (
    .clk        (clk),
    .rst        (rst),
    .seed_valid (seed_valid),
    .seed_ready (seed_ready),
    .seed_value (seed_value),
    .key_valid  (key_valid),
    .key_ready  (key_ready),
    .key_value  (key_value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // byte offset picked by its low two bits, wrapped to 8 bits, then rotated left by 3
  function automatic logic [7:0] scramble_byte(input logic [7:0] b);
    logic [7:0] offset;
    logic [7:0] sum;
    case (b[1:0])
      2'd0: offset = 8'd145;
      2'd1: offset = 8'd24;
      2'd2: offset = 8'd211;
      default: offset = 8'd2;
    endcase
    sum = b + offset;
    return {sum[4:0], sum[7:5]};
  endfunction

  function automatic int unsigned odd_bytes(input logic [KEY_W-1:0] seed);
    int unsigned count;
    count = 0;
    for (int i = 0; i < 4; i++) count += scramble_byte(seed[8*i +: 8]) & 8'd1;
    return count;
  endfunction

  function automatic logic [KEY_W-1:0] seed_to_key(input logic [KEY_W-1:0] seed);
    logic [7:0]  mixed [4];
    logic [7:0]  n [4];
    logic [1:0]  src [4];
    logic [15:0] pair;
    logic [15:0] word0;
    logic [15:0] word1;
    int unsigned odd;
    odd = 0;
    for (int i = 0; i < 4; i++) begin
      mixed[i] = scramble_byte(seed[24-8*i +: 8]);
      odd += mixed[i][0];
    end
    case (odd)
      0: src = '{2'd1, 2'd3, 2'd2, 2'd0};
      1: src = '{2'd3, 2'd2, 2'd0, 2'd1};
      2: src = '{2'd1, 2'd2, 2'd3, 2'd0};
      3: src = '{2'd1, 2'd0, 2'd2, 2'd3};
      default: src = '{2'd2, 2'd0, 2'd1, 2'd3};
    endcase
    for (int j = 0; j < 4; j++) n[j] = mixed[src[j]];
    pair  = {n[0], n[1]};
    word0 = pair * 16'd3 + {5'd0, n[3], 3'd0};
    pair  = {n[2], n[3]};
    word1 = pair * 16'd5 + {5'd0, n[1], 3'd0};
    return {word0, word1};
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_W-1:0] random_seed();
    logic [KEY_W-1:0] s;
    logic [7:0]       corner [8];
    corner = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h70, 8'h6F, 8'hFE, 8'h2D};
    s = $urandom();
    if ($urandom_range(0, 9) < 3) begin
      for (int i = 0; i < 4; i++)
        if ($urandom_range(0, 1)) s[8*i +: 8] = corner[$urandom_range(0, 7)];
    end
    return s;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      seed_valid <= 1'b0;
      seed_value <= '0;
    end else begin
      if (seed_valid && seed_ready) begin
        key_expected.insert(key_expected.size(),
                            '{seed: seed_value, key: seed_to_key(seed_value)});
        seeds_taken++;
      end
      if (!seed_valid || seed_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          seed_valid <= 1'b0;
        end else if (seed_pending.size() > 0) begin
          seed_value <= seed_pending.pop_front();
          seed_valid <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
          end else begin
            send_gap = pick_idle();
            if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(30, 120);
          end
        end else begin
          seed_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      key_ready <= 1'b0;
    end else begin
      if (key_valid && key_ready) begin
        keys_seen++;
        if (key_expected.size() == 0) begin
          error_count++;
          $display("%0t: key transaction with none expected, actual %08h", $time, key_value);
        end else begin
          key_check_t want;
          want = key_expected.pop_front();
          if (key_value !== want.key) begin
            error_count++;
            $display("%0t: seed %08h expected key %08h actual %08h",
                     $time, want.seed, want.key, key_value);
          end
        end
        if (keys_seen == HOLD_AT_KEY && !long_hold_done) begin
          long_hold_done = 1'b1;
          recv_hold = LONG_HOLD;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        key_ready <= 1'b0;
      end else begin
        key_ready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          recv_hold = pick_idle();
          if ($urandom_range(0, 29) == 0) recv_calm = $urandom_range(30, 120);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (seed_valid && seed_ready) || (key_valid && key_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [KEY_W-1:0] s;
    // extremes, every offset select per byte, byte wrap, alternating bits
    seed_pending = {seed_pending, 32'h00000000};
    seed_pending = {seed_pending, 32'hFFFFFFFF};
    seed_pending = {seed_pending, 32'h00010203};
    seed_pending = {seed_pending, 32'hFCFDFEFF};
    seed_pending = {seed_pending, 32'h70FE2D6F};
    seed_pending = {seed_pending, 32'h7F808182};
    seed_pending = {seed_pending, 32'h55555555};
    seed_pending = {seed_pending, 32'hAAAAAAAA};
    seed_pending = {seed_pending, 32'h80000001};
    seed_pending = {seed_pending, 32'h12345678};
    // one seed for each odd-byte count
    for (int k = 0; k <= 4; k++) begin
      do s = $urandom(); while (odd_bytes(s) != k);
      seed_pending = {seed_pending, s};
    end
    for (int i = 0; i < RANDOM_SEEDS; i++) seed_pending = {seed_pending, random_seed()};
    seeds_total = seed_pending.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (seeds_taken == seeds_total);
    wait (key_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (key_expected.size() != 0) begin
      error_count++;
      $display("%0t: %0d keys never arrived", $time, key_expected.size());
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/skt_pkg.sv
rtl/skt_mix.sv
rtl/skt_combine.sv
rtl/seed_to_key_transform.sv
dv/seed_to_key_transform_test.sv
